// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by first_substring_match_finder_core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define FSMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");

// checked on every clock edge, reset included
`define FSMF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: label");

`endif

// ----- rtl/fsmf_pkg.sv -----
// ----------------------------------------------------------------------------
// fsmf_pkg
// types and constants of the first substring match finder
// ----------------------------------------------------------------------------
package fsmf_pkg;

   localparam int MAX_NEEDLE_DEFAULT    = 32;
   localparam int POSITION_BITS_DEFAULT = 32;

   localparam int NEEDLE_STORE_BYTES = 32;
   localparam int NEEDLE_REGS        = 4;
   localparam int LENGTH_BITS        = 6;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 64;
   localparam int OUT_POSITION_BITS  = 32;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_0_7    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_8_15   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_16_23  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_24_31  = 3'd4;

   // per-cell control
   typedef struct packed {
      logic shift;    // window advances by one byte
      logic active;   // cell lies inside the needle length
   } cell_ctrl_type;

endpackage

// ----- rtl/fsmf_cell.sv -----
// ----------------------------------------------------------------------------
// fsmf_cell
// one window cell: holds a text byte and compares the byte shifting in
// ----------------------------------------------------------------------------
module fsmf_cell
   import fsmf_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    byte_in,
   input  logic [7:0]    needle_byte,
   output logic [7:0]    byte_out,
   output logic          match
);

   logic [7:0] held_ff;
   logic [7:0] held_in;

   assign held_in = ctrl.shift ? byte_in : held_ff;

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   assign byte_out = held_ff;
   // cells past the needle length never block a match
   assign match    = !ctrl.active || (byte_in == needle_byte);

endmodule

// ----- rtl/first_substring_match_finder_core.sv -----
// ----------------------------------------------------------------------------
// first_substring_match_finder_core
// streaming search for the first occurrence of a configured needle
// ----------------------------------------------------------------------------
//
//   channel  ports               dir   moves
//   -------  ------------------  ----  ------------------------------------
//   req      req_valid/ready     in    one text byte, last-byte flag
//   rsp      rsp_valid/ready     out   found flag and match position
//   csr      csr_valid/ready     in    register index and 64-bit data
//
// one request per cycle unless the output register stalls; a result appears
// in the cycle after the request that causes it, from the output register
// the window is a row of MAX_NEEDLE byte cells; each cell compares the byte
// entering it against its needle byte, and the match is the and of the row
// reset clears the needle registers, byte counter, match flag and output
// valid; window bytes carry no reset, the byte counter gates them
// req_ready drops only while a result sits in the output register and
// rsp_ready is low; csr_ready is always high
//
module first_substring_match_finder_core
   import fsmf_pkg::*;
#(
   parameter int MAX_NEEDLE    = MAX_NEEDLE_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_text_byte,
   input  logic                          req_last_byte,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [OUT_POSITION_BITS-1:0]  rsp_position,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

`include "assert_macros.svh"

   // wide enough to hold the count and the output position
   localparam int WIDE_BITS = (POSITION_BITS > OUT_POSITION_BITS) ?
                              POSITION_BITS : OUT_POSITION_BITS;

   // configuration registers
   logic [LENGTH_BITS-1:0]   needle_length_ff;
   logic [CSR_DATA_BITS-1:0] needle_ff [NEEDLE_REGS];

   // search state
   logic [POSITION_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic                     match_reported_ff, match_reported_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [OUT_POSITION_BITS-1:0] rsp_position_ff, rsp_position_in;

   logic                     req_fire;
   logic                     rsp_load;
   logic                     found_now;
   logic                     row_match;
   logic [LENGTH_BITS-1:0]   len;
   logic [POSITION_BITS-1:0] seen_next;
   logic [POSITION_BITS-1:0] pos_diff;
   logic [WIDE_BITS-1:0]     pos_wide;

   logic [7:0]               cell_byte  [MAX_NEEDLE];
   logic [MAX_NEEDLE-1:0]    cell_match;
   logic                     shift;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= '0;
         for (int r = 0; r < NEEDLE_REGS; r++) begin
            needle_ff[r] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NEEDLE_LENGTH: needle_length_ff <= csr_data[LENGTH_BITS-1:0];
            CSR_NEEDLE_0_7:    needle_ff[0] <= csr_data;
            CSR_NEEDLE_8_15:   needle_ff[1] <= csr_data;
            CSR_NEEDLE_16_23:  needle_ff[2] <= csr_data;
            CSR_NEEDLE_24_31:  needle_ff[3] <= csr_data;
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // needle length clamped to the window size
   assign len = (needle_length_ff > LENGTH_BITS'(MAX_NEEDLE)) ?
                LENGTH_BITS'(MAX_NEEDLE) : needle_length_ff;

   // a new request is taken unless a result is stuck in the output register
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // the window only moves while the text is still being searched
   assign shift = req_fire && !match_reported_ff;

   // row of window cells; cell k sees the byte that is k requests old
   for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
      logic [LENGTH_BITS-1:0] nidx;
      logic [7:0]             nbyte;
      logic [7:0]             bin;
      cell_ctrl_type          ctrl;

      // cell k lines up with needle byte len-1-k
      assign nidx  = len - LENGTH_BITS'(1) - LENGTH_BITS'(k);
      assign nbyte = needle_ff[nidx[4:3]][{nidx[2:0], 3'b000} +: 8];
      assign ctrl.shift  = shift;
      assign ctrl.active = LENGTH_BITS'(k) < len;

      if (k == 0) begin : g_head
         assign bin = req_text_byte;
      end else begin : g_body
         assign bin = cell_byte[k-1];
      end

      fsmf_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .byte_in     (bin),
         .needle_byte (nbyte),
         .byte_out    (cell_byte[k]),
         .match       (cell_match[k])
      );
   end

   assign row_match = &cell_match;

   // saturating byte count including this request
   assign seen_next = (bytes_seen_ff == '1) ? bytes_seen_ff :
                      bytes_seen_ff + POSITION_BITS'(1);

   // match needs len bytes of the current text in the window
   assign found_now = !match_reported_ff &&
                      ((len == '0) ||
                       ((seen_next >= POSITION_BITS'(len)) && row_match));

   // start of the match, then cut to the output width
   assign pos_diff = seen_next - POSITION_BITS'(len);
   assign pos_wide = WIDE_BITS'(pos_diff);

   assign rsp_load = req_fire && !match_reported_ff && (found_now || req_last_byte);

   always_comb begin
      bytes_seen_in     = bytes_seen_ff;
      match_reported_in = match_reported_ff;
      if (req_fire) begin
         if (req_last_byte) begin
            // text ends, ready for the next one
            bytes_seen_in     = '0;
            match_reported_in = 1'b0;
         end else if (!match_reported_ff) begin
            bytes_seen_in     = seen_next;
            match_reported_in = found_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff     <= '0;
         match_reported_ff <= 1'b0;
      end else begin
         bytes_seen_ff     <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = found_now;
         rsp_position_in = (found_now && (len != '0)) ?
                           pos_wide[OUT_POSITION_BITS-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // checks
   `FSMF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid_ff && (bytes_seen_ff == '0))
   `FSMF_ASSERT(a_silent_after_match, clock, reset, req_fire && match_reported_ff |-> !rsp_load)
   `FSMF_ASSERT(a_last_ends_text, clock, reset,
      req_fire && req_last_byte |=> (bytes_seen_ff == '0) && !match_reported_ff)
   `FSMF_ASSERT(a_stall_only_when_full, clock, reset, !req_ready |-> rsp_valid_ff && !rsp_ready)
   `FSMF_ASSERT(a_not_found_at_zero, clock, reset, rsp_valid_ff && !rsp_found_ff |-> rsp_position_ff == '0)

endmodule
